>>> rtl/device_attach_state_tracker_defines.svh
// assertion macros used by dast_core
`ifndef DEVICE_ATTACH_STATE_TRACKER_DEFINES_SVH
`define DEVICE_ATTACH_STATE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS

// checked every cycle outside reset
`define DAST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dast assertion failed");

// checked every cycle, reset included
`define DAST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("dast assertion failed");

`else

`define DAST_ASSERT(lbl, prop)
`define DAST_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/dast_pkg.sv
package dast_pkg;

  // device states
  typedef enum logic [2:0] {
    ST_STOPPED    = 3'd0,
    ST_WAITING    = 3'd1,
    ST_INSPECTING = 3'd2,
    ST_AVAILABLE  = 3'd3,
    ST_SESSION    = 3'd4,
    ST_CONFLICT   = 3'd5,
    ST_FAULTED    = 3'd6
  } state_t;

  // event kinds, codes above failure are invalid
  typedef enum logic [3:0] {
    EV_START    = 4'd0,
    EV_ATTACH   = 4'd1,
    EV_ACCEPT   = 4'd2,
    EV_OPEN     = 4'd3,
    EV_CLOSE    = 4'd4,
    EV_DETACH   = 4'd5,
    EV_MULTIPLE = 4'd6,
    EV_FAILURE  = 4'd7
  } event_t;

  // result status
  typedef enum logic [1:0] {
    RES_OK             = 2'd0,
    RES_BAD_KIND       = 2'd1,
    RES_BAD_TRANSITION = 2'd2
  } status_t;

  localparam logic [7:0] MultipleMin = 8'd2;

  // one input event
  typedef struct packed {
    logic [3:0]         kind;
    logic [15:0]        vendor;
    logic [15:0]        product;
    logic [6:0]         address;
    logic [31:0]        generation;
    logic [31:0]        revision;
    logic [7:0]         count;
    logic signed [31:0] error_code;
  } ev_t;

  // tracked device snapshot
  typedef struct packed {
    state_t             state;
    logic [15:0]        vendor;
    logic [15:0]        product;
    logic [6:0]         address;
    logic [31:0]        generation;
    logic [7:0]         count;
    logic               recovery;
    logic [31:0]        revision;
    logic signed [31:0] last_error;
  } snap_t;

  // one result
  typedef struct packed {
    status_t status;
    snap_t   snap;
  } res_t;

endpackage

>>> rtl/dast_in_stage.sv
module dast_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dast_pkg::ev_t   in_ev,
  output logic            ev_valid,
  input  logic            down_ready,
  output dast_pkg::ev_t   ev
);

  // register accepts a new transfer when empty or being drained
  assign in_ready = !ev_valid || down_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (in_ready) begin
      ev_valid <= in_valid;
    end
  end

  // event payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ev <= in_ev;
    end
  end

endmodule

>>> rtl/dast_core.sv
`include "device_attach_state_tracker_defines.svh"

module dast_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  dast_pkg::ev_t   ev,
  output dast_pkg::res_t  res
);

  dast_pkg::snap_t   st;
  dast_pkg::snap_t   st_next;
  dast_pkg::status_t status_c;
  logic              carries_rev;
  logic              stale;

  // events that carry a topology revision
  assign carries_rev = ev.kind inside {dast_pkg::EV_ATTACH, dast_pkg::EV_ACCEPT,
                                       dast_pkg::EV_DETACH, dast_pkg::EV_MULTIPLE};
  assign stale = carries_rev && (ev.revision != 32'd0) && (ev.revision < st.revision);

  // next tracker state and status
  always_comb begin
    st_next  = st;
    status_c = dast_pkg::RES_OK;
    if (stale) begin
      status_c = dast_pkg::RES_BAD_TRANSITION;
    end else begin
      case (ev.kind)
        dast_pkg::EV_START: begin
          if (st.state != dast_pkg::ST_STOPPED) begin
            status_c = dast_pkg::RES_BAD_TRANSITION;
          end else begin
            st_next.state = dast_pkg::ST_WAITING;
          end
        end
        dast_pkg::EV_ATTACH: begin
          if (st.state != dast_pkg::ST_WAITING) begin
            status_c = dast_pkg::RES_BAD_TRANSITION;
          end else begin
            st_next.vendor     = ev.vendor;
            st_next.product    = ev.product;
            st_next.address    = ev.address;
            st_next.generation = ev.generation;
            st_next.count      = 8'd0;
            st_next.state      = dast_pkg::ST_INSPECTING;
          end
        end
        dast_pkg::EV_ACCEPT: begin
          if ((st.state != dast_pkg::ST_INSPECTING) || (ev.vendor != st.vendor) ||
              (ev.product != st.product) || (ev.address != st.address) ||
              (ev.generation != st.generation)) begin
            status_c = dast_pkg::RES_BAD_TRANSITION;
          end else begin
            st_next.count = 8'd1;
            st_next.state = dast_pkg::ST_AVAILABLE;
          end
        end
        dast_pkg::EV_OPEN: begin
          if (st.state != dast_pkg::ST_AVAILABLE) begin
            status_c = dast_pkg::RES_BAD_TRANSITION;
          end else begin
            st_next.state = dast_pkg::ST_SESSION;
          end
        end
        dast_pkg::EV_CLOSE: begin
          // close during conflict is taken and ignored
          if (st.state == dast_pkg::ST_SESSION) begin
            st_next.state = dast_pkg::ST_AVAILABLE;
          end else if (st.state != dast_pkg::ST_CONFLICT) begin
            status_c = dast_pkg::RES_BAD_TRANSITION;
          end
        end
        dast_pkg::EV_DETACH: begin
          if (st.state inside {dast_pkg::ST_STOPPED, dast_pkg::ST_WAITING}) begin
            status_c = dast_pkg::RES_BAD_TRANSITION;
          end else if (st.state == dast_pkg::ST_CONFLICT) begin
            // conflict resolves only once no eligible device is left
            st_next.count = ev.count;
            if (ev.count == 8'd0) begin
              st_next.recovery   = 1'b0;
              st_next.vendor     = '0;
              st_next.product    = '0;
              st_next.address    = '0;
              st_next.generation = '0;
              st_next.state      = dast_pkg::ST_WAITING;
            end
          end else begin
            st_next.count      = 8'd0;
            st_next.vendor     = '0;
            st_next.product    = '0;
            st_next.address    = '0;
            st_next.generation = '0;
            st_next.state      = dast_pkg::ST_WAITING;
          end
        end
        dast_pkg::EV_MULTIPLE: begin
          if ((st.state == dast_pkg::ST_STOPPED) || (ev.count < dast_pkg::MultipleMin)) begin
            status_c = dast_pkg::RES_BAD_TRANSITION;
          end else begin
            st_next.vendor     = '0;
            st_next.product    = '0;
            st_next.address    = '0;
            st_next.generation = '0;
            st_next.count      = ev.count;
            st_next.recovery   = 1'b1;
            st_next.state      = dast_pkg::ST_CONFLICT;
          end
        end
        dast_pkg::EV_FAILURE: begin
          st_next.last_error = ev.error_code;
          if (st.state != dast_pkg::ST_CONFLICT) begin
            st_next.state = dast_pkg::ST_FAULTED;
          end
        end
        default: begin
          status_c = dast_pkg::RES_BAD_KIND;
        end
      endcase
      // a zero revision is never stored
      if ((status_c == dast_pkg::RES_OK) && carries_rev && (ev.revision != 32'd0)) begin
        st_next.revision = ev.revision;
      end
    end
  end

  // result is the status and the snapshot after the step
  always_comb begin
    res.status = status_c;
    res.snap   = st_next;
  end

  // tracker registers, all-zero record is the stopped state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // recovery flag is set exactly while in conflict
  `DAST_ASSERT(a_recovery_conflict, st.recovery == (st.state == dast_pkg::ST_CONFLICT))
  // stored revision never goes backward
  `DAST_ASSERT(a_revision_mono, !$past(rst) |-> (st.revision >= $past(st.revision)))
  // state holds when no transfer is processed
  `DAST_ASSERT(a_hold_idle, !fire |=> $stable(st))
  // a rejected event leaves the snapshot unchanged
  `DAST_ASSERT(a_reject_nochange, (fire && (status_c != dast_pkg::RES_OK)) |=> $stable(st))

endmodule

>>> rtl/dast_out_stage.sv
module dast_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  dast_pkg::res_t  res_in,
  output logic            up_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output dast_pkg::res_t  res
);

  // result register frees up when empty or being taken
  assign up_ready = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (up_ready) begin
      out_valid <= load;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

>>> rtl/device_attach_state_tracker.sv
// Attached-device state tracker: one result transfer per event transfer, one event per
// clock cycle sustained; an event passes the input register, then the state update and
// result register; ready runs back from out_ready through both registers, so full rate
// holds whenever the consumer takes every cycle.
module device_attach_state_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         req_type,
  input  logic [15:0]        vendor_code,
  input  logic [15:0]        product_code,
  input  logic [6:0]         bus_address,
  input  logic [31:0]        attach_generation,
  input  logic [31:0]        revision_in,
  input  logic [7:0]         device_count_in,
  input  logic signed [31:0] error_code_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [2:0]         state_out,
  output logic [15:0]        vendor_out,
  output logic [15:0]        product_out,
  output logic [6:0]         address_out,
  output logic [31:0]        generation_out,
  output logic [7:0]         device_count_out,
  output logic               recovery_needed,
  output logic [31:0]        revision_out,
  output logic signed [31:0] last_error_out
);

  dast_pkg::ev_t  in_ev;
  dast_pkg::ev_t  ev;
  dast_pkg::res_t res_c;
  dast_pkg::res_t res_q;
  logic           ev_valid;
  logic           up_ready;
  logic           fire;

  // gather input fields
  always_comb begin
    in_ev.kind       = req_type;
    in_ev.vendor     = vendor_code;
    in_ev.product    = product_code;
    in_ev.address    = bus_address;
    in_ev.generation = attach_generation;
    in_ev.revision   = revision_in;
    in_ev.count      = device_count_in;
    in_ev.error_code = error_code_in;
  end

  dast_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ev      (in_ev),
    .ev_valid   (ev_valid),
    .down_ready (up_ready),
    .ev         (ev)
  );

  // event is processed when the result register can take it
  assign fire = ev_valid && up_ready;

  dast_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .ev   (ev),
    .res  (res_c)
  );

  dast_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_in    (res_c),
    .up_ready  (up_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res_q)
  );

  // spread result fields
  always_comb begin
    status           = res_q.status;
    state_out        = res_q.snap.state;
    vendor_out       = res_q.snap.vendor;
    product_out      = res_q.snap.product;
    address_out      = res_q.snap.address;
    generation_out   = res_q.snap.generation;
    device_count_out = res_q.snap.count;
    recovery_needed  = res_q.snap.recovery;
    revision_out     = res_q.snap.revision;
    last_error_out   = res_q.snap.last_error;
  end

endmodule

>>> sim/dast_tracker_checker.sv
module dast_tracker_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         req_type,
  input  logic [15:0]        vendor_code,
  input  logic [15:0]        product_code,
  input  logic [6:0]         bus_address,
  input  logic [31:0]        attach_generation,
  input  logic [31:0]        revision_in,
  input  logic [7:0]         device_count_in,
  input  logic signed [31:0] error_code_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic [2:0]         state_out,
  input  logic [15:0]        vendor_out,
  input  logic [15:0]        product_out,
  input  logic [6:0]         address_out,
  input  logic [31:0]        generation_out,
  input  logic [7:0]         device_count_out,
  input  logic               recovery_needed,
  input  logic [31:0]        revision_out,
  input  logic signed [31:0] last_error_out,
  output int                 mismatch_count,
  output int                 snapshots_due
);

  // tracked copy of the device record
  dast_pkg::state_t   trk_state;
  logic [15:0]        trk_vendor;
  logic [15:0]        trk_product;
  logic [6:0]         trk_address;
  logic [31:0]        trk_generation;
  logic [7:0]         trk_count;
  logic               trk_recovery;
  logic [31:0]        trk_revision;
  logic signed [31:0] trk_last_error;

  // snapshots still owed by the block, oldest first
  dast_pkg::res_t due_snapshots[$];
  dast_pkg::ev_t  seen_event;
  dast_pkg::res_t owed;
  dast_pkg::res_t got;

  function automatic void drop_identity();
    trk_vendor     = '0;
    trk_product    = '0;
    trk_address    = '0;
    trk_generation = '0;
  endfunction

  // one event against the tracked record, returns the status
  function automatic dast_pkg::status_t track_event(input dast_pkg::ev_t ev);
    dast_pkg::state_t nxt;
    logic             revised;
    revised = ev.kind inside {dast_pkg::EV_ATTACH, dast_pkg::EV_ACCEPT,
                              dast_pkg::EV_DETACH, dast_pkg::EV_MULTIPLE};
    // stale topology revision wins over everything else
    if (revised && ev.revision != '0 && ev.revision < trk_revision)
      return dast_pkg::RES_BAD_TRANSITION;
    nxt = trk_state;
    case (ev.kind)
      dast_pkg::EV_START: begin
        if (trk_state != dast_pkg::ST_STOPPED) return dast_pkg::RES_BAD_TRANSITION;
        nxt = dast_pkg::ST_WAITING;
      end
      dast_pkg::EV_ATTACH: begin
        if (trk_state != dast_pkg::ST_WAITING) return dast_pkg::RES_BAD_TRANSITION;
        trk_vendor     = ev.vendor;
        trk_product    = ev.product;
        trk_address    = ev.address;
        trk_generation = ev.generation;
        trk_count      = '0;
        nxt            = dast_pkg::ST_INSPECTING;
      end
      dast_pkg::EV_ACCEPT: begin
        if (trk_state != dast_pkg::ST_INSPECTING || ev.vendor != trk_vendor ||
            ev.product != trk_product || ev.address != trk_address ||
            ev.generation != trk_generation)
          return dast_pkg::RES_BAD_TRANSITION;
        trk_count = 8'd1;
        nxt       = dast_pkg::ST_AVAILABLE;
      end
      dast_pkg::EV_OPEN: begin
        if (trk_state != dast_pkg::ST_AVAILABLE) return dast_pkg::RES_BAD_TRANSITION;
        nxt = dast_pkg::ST_SESSION;
      end
      dast_pkg::EV_CLOSE: begin
        // close during a conflict is a no-op
        if (trk_state != dast_pkg::ST_CONFLICT) begin
          if (trk_state != dast_pkg::ST_SESSION) return dast_pkg::RES_BAD_TRANSITION;
          nxt = dast_pkg::ST_AVAILABLE;
        end
      end
      dast_pkg::EV_DETACH: begin
        if (trk_state inside {dast_pkg::ST_STOPPED, dast_pkg::ST_WAITING})
          return dast_pkg::RES_BAD_TRANSITION;
        if (trk_state == dast_pkg::ST_CONFLICT) begin
          // conflict clears only once the reported count reaches zero
          trk_count = ev.count;
          if (ev.count == '0) begin
            trk_recovery = 1'b0;
            drop_identity();
            nxt = dast_pkg::ST_WAITING;
          end
        end else begin
          trk_count = '0;
          drop_identity();
          nxt = dast_pkg::ST_WAITING;
        end
      end
      dast_pkg::EV_MULTIPLE: begin
        if (trk_state == dast_pkg::ST_STOPPED || ev.count < dast_pkg::MultipleMin)
          return dast_pkg::RES_BAD_TRANSITION;
        drop_identity();
        trk_count    = ev.count;
        trk_recovery = 1'b1;
        nxt          = dast_pkg::ST_CONFLICT;
      end
      dast_pkg::EV_FAILURE: begin
        trk_last_error = ev.error_code;
        if (trk_state != dast_pkg::ST_CONFLICT) nxt = dast_pkg::ST_FAULTED;
      end
      default: return dast_pkg::RES_BAD_KIND;
    endcase
    trk_state = nxt;
    if (revised && ev.revision != '0) trk_revision = ev.revision;
    return dast_pkg::RES_OK;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%s mismatch: expected %0h, got %0h", field, want, seen);
    end
  endtask

  // watch both channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      trk_state      = dast_pkg::ST_STOPPED;
      drop_identity();
      trk_count      = '0;
      trk_recovery   = 1'b0;
      trk_revision   = '0;
      trk_last_error = '0;
      due_snapshots.delete();
      mismatch_count = 0;
    end else begin
      // event transfer: predict its snapshot
      if (in_valid && in_ready) begin
        seen_event.kind       = req_type;
        seen_event.vendor     = vendor_code;
        seen_event.product    = product_code;
        seen_event.address    = bus_address;
        seen_event.generation = attach_generation;
        seen_event.revision   = revision_in;
        seen_event.count      = device_count_in;
        seen_event.error_code = error_code_in;
        owed.status          = track_event(seen_event);
        owed.snap.state      = trk_state;
        owed.snap.vendor     = trk_vendor;
        owed.snap.product    = trk_product;
        owed.snap.address    = trk_address;
        owed.snap.generation = trk_generation;
        owed.snap.count      = trk_count;
        owed.snap.recovery   = trk_recovery;
        owed.snap.revision   = trk_revision;
        owed.snap.last_error = trk_last_error;
        due_snapshots.push_back(owed);
      end
      // result transfer: compare with the oldest owed snapshot
      if (out_valid && out_ready) begin
        if (due_snapshots.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("result transfer with nothing owed");
        end else begin
          got = due_snapshots.pop_front();
          compare_field("status", 32'(got.status), 32'(status));
          compare_field("state", 32'(got.snap.state), 32'(state_out));
          compare_field("vendor", 32'(got.snap.vendor), 32'(vendor_out));
          compare_field("product", 32'(got.snap.product), 32'(product_out));
          compare_field("address", 32'(got.snap.address), 32'(address_out));
          compare_field("generation", got.snap.generation, generation_out);
          compare_field("device count", 32'(got.snap.count), 32'(device_count_out));
          compare_field("recovery", 32'(got.snap.recovery), 32'(recovery_needed));
          compare_field("revision", got.snap.revision, revision_out);
          compare_field("last error", got.snap.last_error, last_error_out);
        end
      end
    end
    snapshots_due = due_snapshots.size();
  end

endmodule

>>> sim/tb_device_attach_state_tracker.sv
module tb_device_attach_state_tracker;

  localparam logic [3:0] KindFirstInvalid = 4'h8;
  localparam logic [3:0] KindLastInvalid  = 4'hF;
  localparam int         EventTarget      = 1650;
  localparam int         StallLimit       = 1000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [3:0]         req_type;
  logic [15:0]        vendor_code;
  logic [15:0]        product_code;
  logic [6:0]         bus_address;
  logic [31:0]        attach_generation;
  logic [31:0]        revision_in;
  logic [7:0]         device_count_in;
  logic signed [31:0] error_code_in;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [2:0]         state_out;
  logic [15:0]        vendor_out;
  logic [15:0]        product_out;
  logic [6:0]         address_out;
  logic [31:0]        generation_out;
  logic [7:0]         device_count_out;
  logic               recovery_needed;
  logic [31:0]        revision_out;
  logic signed [31:0] last_error_out;
  int                 mismatch_count;
  int                 snapshots_due;

  int            events_sent;
  int            stall_cycles;
  logic          allow_idle;
  logic          wide_revs;
  logic [31:0]   topo_rev;
  dast_pkg::ev_t d;

  device_attach_state_tracker dut (.*);
  dast_tracker_checker chk (.*);

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready = !(allow_idle && $urandom_range(99) < 15);
  end

  // no transfer on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // one event transfer, with an occasional gap ahead of it
  task automatic post_event(input dast_pkg::ev_t ev);
    if (allow_idle && $urandom_range(99) < 15) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid          = 1'b1;
    req_type          = ev.kind;
    vendor_code       = ev.vendor;
    product_code      = ev.product;
    bus_address       = ev.address;
    attach_generation = ev.generation;
    revision_in       = ev.revision;
    device_count_in   = ev.count;
    error_code_in     = ev.error_code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    events_sent++;
  endtask

  // hold off until every owed snapshot has come back
  task automatic wait_drained();
    in_valid = 1'b0;
    while (snapshots_due != 0) @(negedge clk);
  endtask

  // topology revision: mostly rising, sometimes none or stale
  function automatic logic [31:0] next_rev();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 22 && topo_rev > 1) return $urandom_range(topo_rev - 1, 1);
    if (wide_revs) return $urandom();
    topo_rev = topo_rev + $urandom_range(1, 3);
    return topo_rev;
  endfunction

  function automatic dast_pkg::ev_t rand_event(input logic [3:0] kind);
    dast_pkg::ev_t ev;
    ev.kind       = kind;
    ev.vendor     = 16'($urandom());
    ev.product    = 16'($urandom());
    ev.address    = 7'($urandom());
    ev.generation = $urandom();
    ev.revision   = next_rev();
    ev.count      = 8'($urandom());
    ev.error_code = $urandom();
    return ev;
  endfunction

  // a well-formed attach/accept/use/teardown walk with random content
  task automatic run_session();
    dast_pkg::ev_t att;
    dast_pkg::ev_t ev;
    if ($urandom_range(19) == 0) post_event(rand_event(dast_pkg::EV_START));
    att = rand_event(dast_pkg::EV_ATTACH);
    post_event(att);
    ev          = att;
    ev.kind     = dast_pkg::EV_ACCEPT;
    ev.revision = next_rev();
    ev.count    = 8'($urandom());
    // now and then a mismatched identity
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: ev.vendor = ev.vendor ^ (16'd1 << $urandom_range(15));
        1: ev.product = ev.product + 16'd1;
        2: ev.address = ev.address ^ (7'd1 << $urandom_range(6));
        default: ev.generation = ev.generation - 32'd1;
      endcase
    end
    post_event(ev);
    repeat ($urandom_range(0, 3)) begin
      post_event(rand_event(dast_pkg::EV_OPEN));
      post_event(rand_event(dast_pkg::EV_CLOSE));
    end
    if ($urandom_range(1)) post_event(rand_event(dast_pkg::EV_OPEN));
    case ($urandom_range(2))
      0: post_event(rand_event(dast_pkg::EV_DETACH));
      1: begin
        ev = rand_event(dast_pkg::EV_MULTIPLE);
        ev.count = ($urandom_range(9) == 0) ? 8'($urandom_range(1))
                                            : 8'($urandom_range(255, 2));
        post_event(ev);
        post_event(rand_event(dast_pkg::EV_CLOSE));
        if ($urandom_range(2) == 0) post_event(rand_event(dast_pkg::EV_FAILURE));
        ev = rand_event(dast_pkg::EV_DETACH);
        ev.count = 8'($urandom_range(255, 1));
        post_event(ev);
        ev = rand_event(dast_pkg::EV_DETACH);
        ev.count = '0;
        post_event(ev);
      end
      default: begin
        post_event(rand_event(dast_pkg::EV_FAILURE));
        post_event(rand_event(dast_pkg::EV_DETACH));
      end
    endcase
  endtask

  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    req_type          = '0;
    vendor_code       = '0;
    product_code      = '0;
    bus_address       = '0;
    attach_generation = '0;
    revision_in       = '0;
    device_count_in   = '0;
    error_code_in     = '0;
    allow_idle        = 1'b0;
    wide_revs         = 1'b0;
    topo_rev          = '0;
    events_sent       = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed walk through every event kind and corner
    d = '0;
    d.kind = dast_pkg::EV_OPEN;
    post_event(d);
    d = '1;
    d.kind = KindLastInvalid;
    post_event(d);
    d = '0;
    d.kind = KindFirstInvalid;
    post_event(d);
    d.kind  = dast_pkg::EV_MULTIPLE;
    d.count = '1;
    post_event(d);
    d.kind  = dast_pkg::EV_DETACH;
    d.count = '0;
    post_event(d);
    d.kind = dast_pkg::EV_START;
    post_event(d);
    post_event(d);
    // widest identity
    d.kind       = dast_pkg::EV_ATTACH;
    d.vendor     = '1;
    d.product    = '1;
    d.address    = '1;
    d.generation = '1;
    d.revision   = 32'd5;
    post_event(d);
    d.kind    = dast_pkg::EV_ACCEPT;
    d.address = 7'h7E;
    post_event(d);
    // matching identity but stale revision
    d.address  = '1;
    d.revision = 32'd4;
    post_event(d);
    d.revision = '0;
    post_event(d);
    d.kind = dast_pkg::EV_OPEN;
    post_event(d);
    d.kind = dast_pkg::EV_CLOSE;
    post_event(d);
    d.kind = dast_pkg::EV_OPEN;
    post_event(d);
    // too few devices, then a real conflict
    d.kind     = dast_pkg::EV_MULTIPLE;
    d.count    = 8'd1;
    d.revision = 32'd6;
    post_event(d);
    d.count = 8'd2;
    post_event(d);
    d.kind = dast_pkg::EV_CLOSE;
    post_event(d);
    d.kind       = dast_pkg::EV_FAILURE;
    d.error_code = 32'h8000_0000;
    post_event(d);
    d.kind     = dast_pkg::EV_DETACH;
    d.count    = '1;
    d.revision = 32'd7;
    post_event(d);
    d.count    = '0;
    d.revision = '0;
    post_event(d);
    // equal revision is not stale
    d = '0;
    d.kind     = dast_pkg::EV_ATTACH;
    d.revision = 32'd7;
    post_event(d);
    d.kind       = dast_pkg::EV_FAILURE;
    d.error_code = 32'h7FFF_FFFF;
    post_event(d);
    d.kind     = dast_pkg::EV_DETACH;
    d.revision = 32'd8;
    post_event(d);
    d.kind  = dast_pkg::EV_MULTIPLE;
    d.count = '1;
    post_event(d);
    d.kind  = dast_pkg::EV_DETACH;
    d.count = '0;
    post_event(d);
    topo_rev = 32'd8;
    wait_drained();

    // random sessions mixed with noise
    allow_idle = 1'b1;
    while (events_sent < EventTarget) begin
      allow_idle = !(events_sent >= 700 && events_sent < 1000);
      if (events_sent >= 1100 && events_sent < 1110) wait_drained();
      if (events_sent >= 1500) wide_revs = 1'b1;
      if ($urandom_range(9) < 7) begin
        run_session();
      end else begin
        repeat ($urandom_range(1, 4)) post_event(rand_event(4'($urandom_range(15))));
      end
    end
    // top revision at the very end
    d = rand_event(dast_pkg::EV_MULTIPLE);
    d.revision = '1;
    post_event(d);
    d = rand_event(dast_pkg::EV_DETACH);
    d.revision = 32'hFFFF_FFFE;
    post_event(d);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && snapshots_due == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
